// ===== src/hrbs_pkg.sv =====
// Shared constants and types for the holding register bank server.
`default_nettype none

package hrbs_pkg;

    // Field widths fixed by the request format
    localparam int DATA_W = 16;
    localparam int CMD_W  = 2;

    // Default bank geometry
    localparam int NUM_REGS_DEF  = 256;
    localparam int MAX_COUNT_DEF = 64;

    // Configuration port
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    // Register index, taken from byte address bit 2
    localparam logic REG_ADDRESS_OFFSET = 1'b0;

    typedef logic [CMD_W-1:0] t_cmd;

    // Request kinds
    localparam t_cmd CMD_READ         = 2'd0;
    localparam t_cmd CMD_WRITE_SINGLE = 2'd1;
    localparam t_cmd CMD_WRITE_MULTI  = 2'd2;

endpackage

`default_nettype wire

// ===== src/hrbs_store.sv =====
// Single-port register store with registered read data.
`default_nettype none

module hrbs_store #(
    parameter int DEPTH = hrbs_pkg::NUM_REGS_DEF,
    parameter int AW    = 8
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_we,
    input  wire logic [AW-1:0]               i_addr,
    input  wire logic [hrbs_pkg::DATA_W-1:0] i_wdata,
    output logic      [hrbs_pkg::DATA_W-1:0] o_rdata
);

    logic [hrbs_pkg::DATA_W-1:0] r_mem [DEPTH];
    logic [hrbs_pkg::DATA_W-1:0] r_rdata;

    // Write port; read data is registered and returns the old contents
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== src/hrbs_apb_regs.sv =====
// APB-style configuration register holding the address offset.
`default_nettype none

module hrbs_apb_regs (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [hrbs_pkg::PADDR_W-1:0] paddr,
    input  wire logic [hrbs_pkg::PDATA_W-1:0] pwdata,
    output logic      [hrbs_pkg::PDATA_W-1:0] prdata,
    output logic                              pready,
    output logic      [hrbs_pkg::DATA_W-1:0]  o_address_offset
);

    logic [hrbs_pkg::DATA_W-1:0] r_offset;
    logic                        hit;

    assign hit    = (paddr[2] == hrbs_pkg::REG_ADDRESS_OFFSET);
    assign pready = 1'b1;

    // Register write on the access phase
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset <= '0;
        end else if (psel && penable && pwrite && hit) begin
            r_offset <= pwdata[hrbs_pkg::DATA_W-1:0];
        end
    end

    // Read back, zero for unmapped addresses
    always_comb begin
        prdata = '0;
        if (hit) begin
            prdata = {{(hrbs_pkg::PDATA_W-hrbs_pkg::DATA_W){1'b0}}, r_offset};
        end
    end

    assign o_address_offset = r_offset;

endmodule

`default_nettype wire

// ===== src/holding_register_bank_server_top.sv =====
// Top level of the holding register bank server: request decode and store sequencing.
//
//  Channel   Handshake               Payload
//  --------  ----------------------  ------------------------------------------
//  request   start high, busy low    i_cmd i_address i_count i_value i_first_word
//  result    o_valid for one cycle   o_data_word o_status o_last
//  config    psel penable pwrite     paddr pwdata prdata (pready always high)
//
// Writes and rejected requests leave busy low; their result shows in the next cycle.
// A legal read holds busy while it reads, one store read per cycle through the
// single store port; each word comes out in the cycle after its read.
// After reset the store is cleared one entry a cycle, with busy high until all are cleared.
// The receiver cannot stall: every result is shown for exactly one cycle.
`default_nettype none

module holding_register_bank_server_top #(
    parameter int NUM_REGS  = hrbs_pkg::NUM_REGS_DEF,
    parameter int MAX_COUNT = hrbs_pkg::MAX_COUNT_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         start,
    output logic                              busy,
    input  wire logic [hrbs_pkg::CMD_W-1:0]   i_cmd,
    input  wire logic [hrbs_pkg::DATA_W-1:0]  i_address,
    input  wire logic [hrbs_pkg::DATA_W-1:0]  i_count,
    input  wire logic [hrbs_pkg::DATA_W-1:0]  i_value,
    input  wire logic                         i_first_word,
    output logic                              o_valid,
    output logic      [hrbs_pkg::DATA_W-1:0]  o_data_word,
    output logic                              o_status,
    output logic                              o_last,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [hrbs_pkg::PADDR_W-1:0] paddr,
    input  wire logic [hrbs_pkg::PDATA_W-1:0] pwdata,
    output logic      [hrbs_pkg::PDATA_W-1:0] prdata,
    output logic                              pready
);

    localparam int AW = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
    localparam int CW = $clog2(MAX_COUNT + 1);
    localparam int DW = hrbs_pkg::DATA_W;

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_READ  = 2'd2;

    logic [1:0]    r_state, n_state;
    logic [AW-1:0] r_clr_addr, n_clr_addr;
    logic [AW-1:0] r_rd_addr, n_rd_addr;
    logic [CW-1:0] r_rd_left, n_rd_left;
    logic          r_rd_pend, n_rd_pend;
    logic          r_rd_last, n_rd_last;
    logic [AW-1:0] r_ptr, n_ptr;
    logic [CW-1:0] r_rem, n_rem;
    logic [CW-1:0] r_pend, n_pend;
    logic          r_discard, n_discard;
    logic          r_res_valid, n_res_valid;
    logic          r_res_status, n_res_status;
    logic [DW-1:0] r_res_data, n_res_data;

    logic [DW-1:0] offset;
    logic [DW-1:0] mem_rdata;
    logic          mem_we;
    logic [AW-1:0] mem_addr;
    logic [DW-1:0] mem_wdata;

    logic          acc;
    logic          addr_ge;
    logic [DW-1:0] rel;
    logic [DW:0]   span_end;
    logic          cnt_ok;
    logic          range_ok;
    logic          single_ok;

    hrbs_apb_regs u_regs (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .o_address_offset (offset)
    );

    hrbs_store #(
        .DEPTH (NUM_REGS),
        .AW    (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_addr  (mem_addr),
        .i_wdata (mem_wdata),
        .o_rdata (mem_rdata)
    );

    // Range checks on the request address after the offset
    assign acc       = start && (r_state == ST_IDLE);
    assign addr_ge   = (i_address >= offset);
    assign rel       = i_address - offset;
    assign span_end  = {1'b0, rel} + {1'b0, i_count};
    assign cnt_ok    = (i_count != '0) && (i_count <= DW'(MAX_COUNT));
    assign range_ok  = addr_ge && cnt_ok && (span_end <= (DW+1)'(NUM_REGS));
    assign single_ok = addr_ge && ({1'b0, rel} < (DW+1)'(NUM_REGS));

    // Sequencer: clearing pass, request decode, read burst
    always_comb begin
        n_state      = r_state;
        n_clr_addr   = r_clr_addr;
        n_rd_addr    = r_rd_addr;
        n_rd_left    = r_rd_left;
        n_rd_pend    = 1'b0;
        n_rd_last    = 1'b0;
        n_ptr        = r_ptr;
        n_rem        = r_rem;
        n_pend       = r_pend;
        n_discard    = r_discard;
        n_res_valid  = 1'b0;
        n_res_status = 1'b0;
        n_res_data   = '0;
        mem_we       = 1'b0;
        mem_addr     = r_rd_addr;
        mem_wdata    = i_value;

        case (r_state)
            ST_CLEAR: begin
                mem_we     = 1'b1;
                mem_addr   = r_clr_addr;
                mem_wdata  = '0;
                n_clr_addr = r_clr_addr + AW'(1);
                if (r_clr_addr == AW'(NUM_REGS - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (acc) begin
                    case (i_cmd)
                        hrbs_pkg::CMD_READ: begin
                            if (range_ok) begin
                                n_state   = ST_READ;
                                n_rd_addr = rel[AW-1:0];
                                n_rd_left = i_count[CW-1:0];
                            end else begin
                                n_res_valid  = 1'b1;
                                n_res_status = 1'b1;
                            end
                        end
                        hrbs_pkg::CMD_WRITE_SINGLE: begin
                            n_res_valid = 1'b1;
                            if (single_ok) begin
                                mem_we     = 1'b1;
                                mem_addr   = rel[AW-1:0];
                                n_res_data = i_value;
                            end else begin
                                n_res_status = 1'b1;
                            end
                        end
                        hrbs_pkg::CMD_WRITE_MULTI: begin
                            if (i_first_word) begin
                                if (range_ok) begin
                                    mem_we    = 1'b1;
                                    mem_addr  = rel[AW-1:0];
                                    n_discard = 1'b0;
                                    n_ptr     = rel[AW-1:0] + AW'(1);
                                    n_rem     = i_count[CW-1:0] - CW'(1);
                                    n_pend    = i_count[CW-1:0];
                                    if (i_count[CW-1:0] == CW'(1)) begin
                                        n_res_valid = 1'b1;
                                        n_res_data  = {{(DW-CW){1'b0}}, i_count[CW-1:0]};
                                    end
                                end else begin
                                    n_discard    = 1'b1;
                                    n_rem        = '0;
                                    n_pend       = '0;
                                    n_res_valid  = 1'b1;
                                    n_res_status = 1'b1;
                                end
                            end else if (!r_discard && (r_rem != '0)) begin
                                mem_we   = 1'b1;
                                mem_addr = r_ptr;
                                n_ptr    = r_ptr + AW'(1);
                                n_rem    = r_rem - CW'(1);
                                if (r_rem == CW'(1)) begin
                                    n_res_valid = 1'b1;
                                    n_res_data  = {{(DW-CW){1'b0}}, r_pend};
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_READ: begin
                mem_addr  = r_rd_addr;
                n_rd_addr = r_rd_addr + AW'(1);
                n_rd_left = r_rd_left - CW'(1);
                n_rd_pend = 1'b1;
                n_rd_last = (r_rd_left == CW'(1));
                if (r_rd_left == CW'(1)) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control and transfer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_addr  <= '0;
            r_rd_pend   <= 1'b0;
            r_rd_last   <= 1'b0;
            r_ptr       <= '0;
            r_rem       <= '0;
            r_pend      <= '0;
            r_discard   <= 1'b0;
            r_res_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_rd_pend   <= n_rd_pend;
            r_rd_last   <= n_rd_last;
            r_ptr       <= n_ptr;
            r_rem       <= n_rem;
            r_pend      <= n_pend;
            r_discard   <= n_discard;
            r_res_valid <= n_res_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_rd_addr    <= n_rd_addr;
        r_rd_left    <= n_rd_left;
        r_res_status <= n_res_status;
        r_res_data   <= n_res_data;
    end

    // Result ports: read data from the store, else the registered reply
    assign busy        = (r_state != ST_IDLE);
    assign o_valid     = r_rd_pend || r_res_valid;
    assign o_data_word = r_rd_pend ? mem_rdata : r_res_data;
    assign o_status    = r_res_valid && r_res_status;
    assign o_last      = r_rd_pend ? r_rd_last : r_res_valid;

`ifndef SYNTHESIS
    // Read words and immediate replies never collide
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_rd_pend && r_res_valid))
        else $error("read word and reply in the same cycle");

    // An exception reply is a single marked result with zero data
    a_err_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status) |-> (o_last && (o_data_word == '0)))
        else $error("malformed exception reply");

    // Words remaining never exceed the request limit
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ({{(32-CW){1'b0}}, r_rem} <= 32'(MAX_COUNT)))
        else $error("write multiple count out of range");

    // A read burst ends with its last word in the cycle after its last read
    a_read_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_READ) && (r_rd_left == CW'(1))) |=> (r_rd_pend && r_rd_last))
        else $error("read burst lost its last word");
`endif

endmodule

`default_nettype wire
